// ===== hw/rtl/kss_pkg.sv =====
// Shared types and constants for the KMP substring search unit.
// No dependencies.
package kss_pkg;

   localparam int CHAR_W  = 8;
   localparam int INDEX_W = 16;

   typedef logic [CHAR_W-1:0]  char_type;
   typedef logic [INDEX_W-1:0] index_type;

   // item kind carried on req_tuser
   typedef enum logic {
      OP_PATTERN = 1'b0,
      OP_TEXT    = 1'b1
   } op_type;

endpackage

// ===== hw/rtl/kmp_substring_search_unit.sv =====
// KMP substring search unit: pattern store, failure table and match sequencer.
// Depends on kss_pkg.
//
// Usage
//   req channel: one byte per item. req_tuser selects a pattern byte (0) or a
//   text byte (1), req_tdata carries the byte and req_tlast marks the final
//   byte of the pattern or of the text. Pattern bytes build the stored pattern
//   and its failure table; text bytes are then matched against it.
//   rsp channel: at most one item per text. rsp_tuser is 1 with rsp_tdata the
//   start index of the first match, or rsp_tuser is 0 with rsp_tdata zero when
//   the final text byte goes by without a match.
//   Timing: a byte that is stored or searched passes from the idle state into
//   the scan state, which it holds longer for each failure-table fallback, the
//   read latency of the pattern and table memories setting the loop. Fallbacks
//   amortise to at most one per byte. A text byte after its result, or an
//   ignored pattern byte beyond PATTERN_DEPTH, is taken in the idle state with
//   no scan. A result shows in the output register in the cycle after the last compare.
//   Reset empties the pattern and the search state; the memories are not
//   cleared, as only written entries are ever read.
//   A stalled rsp side holds the result; the next item is still taken and
//   only waits if it has a result of its own to give.
module kmp_substring_search_unit #(
   parameter int PATTERN_DEPTH    = 64,
   parameter int TEXT_INDEX_WIDTH = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [7:0]                 req_tdata,  // [7:0] char_value
   input  logic                       req_tuser,  // [0] operation
   input  logic                       req_tlast,  // last
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [15:0]                rsp_tdata,  // [15:0] match_index
   output logic                       rsp_tuser   // [0] found
);

   localparam int KW = (PATTERN_DEPTH > 1) ? $clog2(PATTERN_DEPTH) : 1;
   localparam int LW = $clog2(PATTERN_DEPTH + 1);
   localparam int TW = TEXT_INDEX_WIDTH;
   localparam logic [LW-1:0] DEPTH_L = LW'(PATTERN_DEPTH);
   localparam logic [TW-1:0] POS_MAX = {TW{1'b1}};

   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } state_type;

   // memories
   kss_pkg::char_type pat_mem [PATTERN_DEPTH];
   logic [KW-1:0]     fail_mem [PATTERN_DEPTH];
   kss_pkg::char_type pat_rd_ff;
   logic [KW-1:0]     fail_rd_ff;

   state_type          state_ff, state_in;
   logic               op_ff, op_in;
   kss_pkg::char_type  char_ff, char_in;
   logic               last_ff, last_in;
   logic [KW-1:0]      k_ff, k_in;
   logic [KW-1:0]      wpos_ff, wpos_in;
   logic [LW-1:0]      len_ff, len_in;
   logic [KW-1:0]      prefix_ff, prefix_in;
   logic [KW-1:0]      matched_ff, matched_in;
   logic [TW-1:0]      pos_ff, pos_in;
   logic               given_ff, given_in;
   logic               closed_ff, closed_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_found_ff, rsp_found_in;
   kss_pkg::index_type rsp_index_ff, rsp_index_in;

   logic               accept;
   logic [LW-1:0]      eff_len;
   logic [KW-1:0]      eff_prefix;
   logic               pat_we;
   logic [KW-1:0]      pat_waddr;
   logic               fail_we;
   logic [KW-1:0]      rd_addr;
   logic [KW-1:0]      fail_addr;
   logic               fall;
   logic               hit;
   logic [KW-1:0]      next_k;
   logic [LW-1:0]      next_j;
   logic               out_free;
   logic [TW-1:0]      start_pos;
   logic [TW-1:0]      pos_next;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign eff_len    = closed_ff ? '0 : len_ff;
   assign eff_prefix = closed_ff ? '0 : prefix_ff;

   assign hit    = (pat_rd_ff == char_ff);
   assign fall   = (k_ff != '0) && !hit;
   assign next_k = k_ff + KW'(hit);
   assign next_j = LW'(k_ff) + LW'(hit);

   assign start_pos = pos_ff + TW'(1) - TW'(len_ff);
   assign pos_next  = (pos_ff != POS_MAX) ? pos_ff + TW'(1) : pos_ff;

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      char_in      = char_ff;
      last_in      = last_ff;
      k_in         = k_ff;
      wpos_in      = wpos_ff;
      len_in       = len_ff;
      prefix_in    = prefix_ff;
      matched_in   = matched_ff;
      pos_in       = pos_ff;
      given_in     = given_ff;
      closed_in    = closed_ff;
      rsp_found_in = rsp_found_ff;
      rsp_index_in = rsp_index_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      pat_we       = 1'b0;
      pat_waddr    = eff_len[KW-1:0];
      fail_we      = 1'b0;
      rd_addr      = k_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in   = req_tuser;
               char_in = req_tdata;
               last_in = req_tlast;
               if (req_tuser == kss_pkg::OP_PATTERN) begin
                  matched_in = '0;
                  pos_in     = '0;
                  given_in   = 1'b0;
                  closed_in  = req_tlast;
                  len_in     = eff_len;
                  prefix_in  = eff_prefix;
                  if (eff_len < DEPTH_L) begin
                     pat_we   = 1'b1;
                     wpos_in  = eff_len[KW-1:0];
                     len_in   = eff_len + LW'(1);
                     k_in     = (LW'(eff_prefix) >= eff_len) ? '0 : eff_prefix;
                     state_in = ST_SCAN;
                  end
               end else begin
                  closed_in = 1'b1;
                  if (given_ff) begin
                     if (req_tlast) begin
                        matched_in = '0;
                        pos_in     = '0;
                        given_in   = 1'b0;
                     end
                  end else begin
                     k_in     = (LW'(matched_ff) >= len_ff) ? '0 : matched_ff;
                     state_in = ST_SCAN;
                  end
               end
               rd_addr = k_in;
            end
         end

         ST_SCAN: begin
            if (op_ff == kss_pkg::OP_PATTERN) begin
               if (wpos_ff == '0) begin
                  // first byte: table entry is zero by definition
                  fail_we   = 1'b1;
                  prefix_in = '0;
                  state_in  = ST_IDLE;
               end else if (fall) begin
                  k_in    = fail_rd_ff;
                  rd_addr = fail_rd_ff;
               end else begin
                  fail_we   = 1'b1;
                  prefix_in = next_k;
                  state_in  = ST_IDLE;
               end
            end else if (len_ff == '0) begin
               // empty pattern matches at once
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_found_in = 1'b1;
                  rsp_index_in = '0;
                  given_in     = 1'b1;
                  pos_in       = pos_next;
                  state_in     = ST_IDLE;
               end
            end else if (fall) begin
               k_in    = fail_rd_ff;
               rd_addr = fail_rd_ff;
            end else if (next_j == len_ff) begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_found_in = 1'b1;
                  rsp_index_in = kss_pkg::INDEX_W'(start_pos);
                  given_in     = 1'b1;
                  matched_in   = '0;
                  pos_in       = pos_next;
                  state_in     = ST_IDLE;
               end
            end else if (last_ff) begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_found_in = 1'b0;
                  rsp_index_in = '0;
                  matched_in   = next_k;
                  pos_in       = pos_next;
                  state_in     = ST_IDLE;
               end
            end else begin
               matched_in = next_k;
               pos_in     = pos_next;
               state_in   = ST_IDLE;
            end

            // end of text: next text searches afresh
            if (op_ff == kss_pkg::OP_TEXT && last_ff && state_in == ST_IDLE) begin
               matched_in = '0;
               pos_in     = '0;
               given_in   = 1'b0;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign fail_addr = (rd_addr == '0) ? '0 : rd_addr - KW'(1);

   always_ff @(posedge clock) begin
      if (pat_we) begin
         pat_mem[pat_waddr] <= req_tdata;
      end
      pat_rd_ff <= pat_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (fail_we) begin
         fail_mem[wpos_ff] <= (wpos_ff == '0) ? '0 : next_k;
      end
      fail_rd_ff <= fail_mem[fail_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         len_ff       <= '0;
         prefix_ff    <= '0;
         matched_ff   <= '0;
         pos_ff       <= '0;
         given_ff     <= 1'b0;
         closed_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         prefix_ff    <= prefix_in;
         matched_ff   <= matched_in;
         pos_ff       <= pos_in;
         given_ff     <= given_in;
         closed_ff    <= closed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff        <= op_in;
      char_ff      <= char_in;
      last_ff      <= last_in;
      k_ff         <= k_in;
      wpos_ff      <= wpos_in;
      rsp_found_ff <= rsp_found_in;
      rsp_index_ff <= rsp_index_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_found_ff;
   assign rsp_tdata  = rsp_index_ff;

endmodule
